// File: sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Round constants, initial hash values, payload structs and control structs.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // Byte source for the block buffer write port
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       push;        // write one byte into the block buffer
    byte_src_t  src;
    logic       count_byte;  // advance the message byte count
    logic       start;       // load working vars and start compression
    logic       round;       // run one round (schedule load or round step)
    logic       feed;        // add working vars into the chain
    logic       init;        // restore initial hash, clear fill and count
    logic       latch_len;   // latch bit length for padding
  } sha_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [5:0] fill;
    logic [2:0] len_idx;
  } sha_stat_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[i];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Channel | direction | payload
// in      | request   | sha_in_t  (data_byte, byte_present, end_of_message)
// out     | result    | sha_out_t (digest_word, word_index, last_word)
// A byte is written while idle; the 64th byte of a block starts compression
// on one round unit, one round per cycle, and ends with a feed-forward step.
// End of message adds pad writes (1 per byte, up to 72 over two blocks), one
// or two compressions, the digest output, which output stalls can hold, and
// a restore step. Reset restores the initial hash and clears the counts.
// Output stall holds the digest word; input stalls while busy.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [2:0]  rd_idx;
  logic [31:0] rd_word;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cmd, .rd_idx, .rd_word, .stat
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .data_byte(in_data.data_byte), .rd_idx, .rd_word, .stat
  );
endmodule

// File: sv/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath: block buffer, message schedule, round logic and chain words
// One round per cycle on a 16-word rolling schedule window.
// ----------------------------------------------------------------------------
module sha_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [7:0]        data_byte,
  input  logic [2:0]        rd_idx,
  output logic [31:0]       rd_word,
  output sha_pkg::sha_stat_t stat
);
  import sha_pkg::*;

  logic [31:0] buffer [16];
  logic [5:0]  fill;
  logic [63:0] byte_count;
  logic [63:0] bit_len;
  logic [2:0]  len_idx;
  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [6:0]  rnd;
  logic [7:0]  wr_byte;
  logic [31:0] w_new, w_cur, t1, t2;

  // Select the byte to write
  always_comb begin
    unique case (cmd.src)
      SRC_DATA: wr_byte = data_byte;
      SRC_PAD:  wr_byte = PAD_BYTE;
      SRC_ZERO: wr_byte = 8'h00;
      SRC_LEN:  wr_byte = bit_len[63 - 8*len_idx -: 8];
      default:  wr_byte = 8'h00;
    endcase
  end

  // Buffer write into big-endian byte lanes, fill and length counters
  always_ff @(posedge clk) begin
    if (cmd.push) buffer[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
    if (rst || cmd.init) begin
      fill <= '0;
      byte_count <= '0;
      len_idx <= '0;
    end else begin
      if (cmd.push) fill <= fill + 6'd1;
      if (cmd.count_byte) byte_count <= byte_count + 64'd1;
      if (cmd.push && cmd.src == SRC_LEN) len_idx <= len_idx + 3'd1;
    end
    if (cmd.latch_len) bit_len <= {byte_count[60:0], 3'b000};
  end

  // Schedule: rounds 0..15 read the buffer, later ones expand
  assign w_new = w[0] + (ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3))
               + w[9] + (ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10));
  always_comb begin
    if (rnd < 7'd16)
      w_cur = buffer[rnd[3:0]];
    else
      w_cur = w_new;
  end

  assign t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd[5:0]) + w_cur;
  assign t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // Working vars, schedule window and chain words
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
      rnd <= '0;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_cur;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      rnd <= rnd + 7'd1;
    end
    if (rst || cmd.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
    end else if (cmd.feed) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
  end

  assign rd_word      = chain[rd_idx];
  assign stat.fill    = fill;
  assign stat.len_idx = len_idx;

  // Round counter never runs past the last round without a restart
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> rnd < 7'd64) else $error("round past 63");
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !cmd.round) else $error("push during compression");
  a_feed_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.feed |-> !cmd.init && !cmd.push) else $error("feed overlaps");
endmodule

// File: sv/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer for byte intake, compression, padding and digest output
// Drives datapath commands and the output register.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha_pkg::sha_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::sha_out_t  out_data,
  output sha_pkg::sha_cmd_t  cmd,
  output logic [2:0]         rd_idx,
  input  logic [31:0]        rd_word,
  input  sha_pkg::sha_stat_t stat
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_FEED  = 6'b000100,
    S_PAD   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_INIT  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic       padding, padding_next;
  logic [6:0] rcnt;
  logic [3:0] emit_cnt;
  logic       accept, full_after, out_take;
  // Pad phase tracking: 0x80 written, length may go in this block, length done
  logic       pad_started;
  logic       len_armed;
  logic       len_done;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Datapath commands and next state
  always_comb begin
    cmd = '0;
    cmd.src = SRC_DATA;
    state_next = state;
    padding_next = padding;
    full_after = (stat.fill == 6'd63);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.push = in_data.byte_present;
          cmd.count_byte = in_data.byte_present;
          if (in_data.byte_present && full_after) begin
            cmd.start = 1'b1;
            state_next = S_ROUND;
            padding_next = in_data.end_of_message;
          end else if (in_data.end_of_message) begin
            state_next = S_PAD;
            padding_next = 1'b1;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (rcnt == 7'd63) state_next = S_FEED;
      end
      S_FEED: begin
        cmd.feed = 1'b1;
        if (len_done) state_next = S_EMIT;
        else state_next = padding ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (!pad_started) begin
          // First pad cycle latches length and writes 0x80
          cmd.src = SRC_PAD;
          cmd.latch_len = 1'b1;
        end else if (len_armed && stat.fill >= LEN_START) begin
          cmd.src = SRC_LEN;
        end else begin
          cmd.src = SRC_ZERO;
        end
        if (full_after) begin
          cmd.start = 1'b1;
          state_next = S_ROUND;
          if (stat.len_idx == 3'd7 && cmd.src == SRC_LEN) padding_next = 1'b0;
        end
      end
      S_EMIT: begin
        if (emit_cnt == 4'd8 && !out_valid) state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      padding <= 1'b0;
      pad_started <= 1'b0;
      len_armed <= 1'b0;
      len_done <= 1'b0;
      out_valid <= 1'b0;
      emit_cnt <= '0;
      rcnt <= '0;
    end else begin
      state <= state_next;
      padding <= padding_next;
      // Round counter
      if (state != S_ROUND) rcnt <= '0;
      else rcnt <= rcnt + 7'd1;
      // Padding progress, cleared for the next message
      if (state == S_INIT) begin
        pad_started <= 1'b0;
        len_armed <= 1'b0;
        len_done <= 1'b0;
      end
      if (cmd.push && cmd.src == SRC_PAD) pad_started <= 1'b1;
      if (state == S_PAD && stat.fill < LEN_START) len_armed <= 1'b1;
      if (cmd.push && cmd.src == SRC_LEN && stat.len_idx == 3'd7) len_done <= 1'b1;
      // Digest output register
      if (state == S_EMIT && emit_cnt < 4'd8 && (!out_valid || out_take)) begin
        out_valid <= 1'b1;
        out_data.digest_word <= rd_word;
        out_data.word_index <= emit_cnt[2:0];
        out_data.last_word <= (emit_cnt == 4'd7);
        emit_cnt <= emit_cnt + 4'd1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (state == S_INIT) emit_cnt <= '0;
    end
  end

  assign rd_idx = emit_cnt[2:0];

  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_emit_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> in_stall) else $error("input taken while emitting");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_word |-> out_data.word_index == 3'd7)
    else $error("last word index");
endmodule
